@@ hdl/utf8_to_code_point_decoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// checks compile in simulation only; synthesis sees empty bodies
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODE_POINT_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define UTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define UTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/utd_pkg.sv @@
// ----------------------------------------------------------------------------
// utd_pkg
// types and constants shared by the utf8 decoder modules
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int CP_W    = 21;
    localparam int COUNT_W = 16;

    // configuration register indexes
    localparam logic CFG_MAX_CODE_POINTS = 1'b0;
    localparam logic CFG_STOP_AT_NUL     = 1'b1;

    localparam logic [COUNT_W-1:0] MAX_CODE_POINTS_RST = 16'd4096;
    localparam logic               STOP_AT_NUL_RST     = 1'b1;

    // lead byte length thresholds
    localparam logic [7:0] LEAD_ONE_LIMIT   = 8'h80;
    localparam logic [7:0] LEAD_TWO_LIMIT   = 8'hE0;
    localparam logic [7:0] LEAD_THREE_LIMIT = 8'hF0;

    // payload masks
    localparam logic [7:0] LEAD_TWO_MASK   = 8'h1F;
    localparam logic [7:0] LEAD_THREE_MASK = 8'h0F;
    localparam logic [7:0] LEAD_FOUR_MASK  = 8'h07;
    localparam logic [7:0] CONT_MASK       = 8'h3F;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]    cp_value;
        logic               has_code_point;
        logic               end_of_string;
        logic               truncated;
        logic [COUNT_W-1:0] units_written;
    } t_result;

    // handshake status from the decode step to the register stages
    typedef struct packed {
        logic advance;
        logic load;
    } t_step_ctl;

endpackage

@@ hdl/utd_in_reg.sv @@
// ----------------------------------------------------------------------------
// utd_in_reg
// input register: holds one byte transaction until the decode step takes it
// ----------------------------------------------------------------------------
module utd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  utd_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output utd_pkg::t_in_item o_item
);
    import utd_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/utd_decode.sv @@
// ----------------------------------------------------------------------------
// utd_decode
// per-string decode state and the single-pass byte step
// ----------------------------------------------------------------------------
`include "utf8_to_code_point_decoder_core_defines.svh"

module utd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  utd_pkg::t_in_item             i_item,
    input  logic                          i_out_free,
    input  logic [utd_pkg::COUNT_W-1:0]   i_max_code_points,
    input  logic                          i_stop_at_nul,
    output utd_pkg::t_step_ctl            o_ctl,
    output utd_pkg::t_result              o_result
);
    import utd_pkg::*;

    logic [1:0]         r_pend, n_pend;
    logic [CP_W-1:0]    r_part, n_part;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_full, n_full;

    logic [7:0]         b;
    logic               nul_end;
    logic               ends;
    logic               have;
    logic               trunc;
    logic               produce;
    logic [CP_W-1:0]    cp;
    logic [CP_W-1:0]    cont_bits;
    logic [7:0]         cont_byte;

    assign b         = i_item.byte_in;
    assign cont_byte = b & CONT_MASK;

    // place the continuation payload by how many bytes are still due
    always_comb begin
        unique case (r_pend)
            2'd3:    cont_bits = {3'b0, cont_byte[5:0], 12'b0};
            2'd2:    cont_bits = {9'b0, cont_byte[5:0], 6'b0};
            default: cont_bits = {15'b0, cont_byte[5:0]};
        endcase
    end

    always_comb begin
        logic [7:0] lead2;
        logic [7:0] lead3;
        logic [7:0] lead4;
        lead2   = b & LEAD_TWO_MASK;
        lead3   = b & LEAD_THREE_MASK;
        lead4   = b & LEAD_FOUR_MASK;
        nul_end = i_stop_at_nul && (b == 8'd0);
        ends    = i_item.last_byte || nul_end;
        n_pend  = r_pend;
        n_part  = r_part;
        n_cnt   = r_cnt;
        n_full  = r_full;
        have    = 1'b0;
        trunc   = 1'b0;
        cp      = '0;

        if (nul_end) begin
            // nul ends the string, flushing any open sequence
            if (r_pend != 2'd0) begin
                cp    = r_part;
                have  = 1'b1;
                trunc = 1'b1;
            end
        end else if (!r_full) begin
            if (r_pend == 2'd0) begin
                if (r_cnt >= i_max_code_points) begin
                    n_full = 1'b1;
                end else if (b < LEAD_ONE_LIMIT) begin
                    cp   = {13'b0, b};
                    have = 1'b1;
                end else if (b < LEAD_TWO_LIMIT) begin
                    n_part = {10'b0, lead2[4:0], 6'b0};
                    n_pend = 2'd1;
                end else if (b < LEAD_THREE_LIMIT) begin
                    n_part = {5'b0, lead3[3:0], 12'b0};
                    n_pend = 2'd2;
                end else begin
                    n_part = {lead4[2:0], 18'b0};
                    n_pend = 2'd3;
                end
            end else begin
                n_part = r_part | cont_bits;
                n_pend = r_pend - 2'd1;
                if (n_pend == 2'd0) begin
                    cp   = n_part;
                    have = 1'b1;
                end
            end
            if (ends && !have && n_pend != 2'd0) begin
                cp    = n_part;
                have  = 1'b1;
                trunc = 1'b1;
            end
        end

        if (have) begin
            n_cnt  = r_cnt + 16'd1;
            n_part = '0;
            n_pend = 2'd0;
        end
    end

    assign produce       = have || ends;
    // an item without a result never waits on the output side
    assign o_ctl.advance = i_valid && (!produce || i_out_free);
    assign o_ctl.load    = o_ctl.advance && produce;

    assign o_result.cp_value       = cp;
    assign o_result.has_code_point = have;
    assign o_result.end_of_string  = ends;
    assign o_result.truncated      = trunc;
    assign o_result.units_written  = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_part <= '0;
            r_cnt  <= '0;
            r_full <= 1'b0;
        end else if (o_ctl.advance) begin
            if (ends) begin
                r_pend <= 2'd0;
                r_part <= '0;
                r_cnt  <= '0;
                r_full <= 1'b0;
            end else begin
                r_pend <= n_pend;
                r_part <= n_part;
                r_cnt  <= n_cnt;
                r_full <= n_full;
            end
        end
    end

    `UTD_ASSERT_NEXT(a_eos_clears, i_clk, i_rst_n, o_ctl.load && ends, (r_pend == 2'd0) && (r_cnt == '0) && !r_full, "string state not cleared after end of string")
    `UTD_ASSERT_NEXT(a_emit_closes_seq, i_clk, i_rst_n, o_ctl.load && have, (r_pend == 2'd0) && (r_part == '0), "sequence still open after emitting a code point")
    `UTD_ASSERT_NOW(a_trunc_flush, i_clk, i_rst_n, i_valid && trunc, ends && have, "truncated flag without a flushed closing result")
    `UTD_ASSERT_NOW(a_full_idle, i_clk, i_rst_n, r_full, r_pend == 2'd0, "sequence open while capacity is full")

endmodule

@@ hdl/utd_out_reg.sv @@
// ----------------------------------------------------------------------------
// utd_out_reg
// result register: holds one result transaction until the consumer takes it
// ----------------------------------------------------------------------------
module utd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  utd_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output utd_pkg::t_result o_result
);
    import utd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/utf8_to_code_point_decoder_core.sv @@
// a byte goes from the input register through the byte step into the result register
// throughput: one byte per cycle while no byte is held by output back-pressure; the byte step
//   between the input and result registers updates the per-string state when it advances
// output back-pressure holds only bytes that produce a result
// reset (synchronous, active low) clears per-string state, both register stages,
//   and loads max_code_points 4096 and stop_at_nul 1
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_core
// utf8 byte stream to code point decoder, without back-pressure one byte transaction per cycle
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [utd_pkg::COUNT_W-1:0] i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_byte_in,
    input  logic                        i_last_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [utd_pkg::CP_W-1:0]    o_cp_value,
    output logic                        o_has_code_point,
    output logic                        o_end_of_string,
    output logic                        o_truncated,
    output logic [utd_pkg::COUNT_W-1:0] o_units_written
);
    import utd_pkg::*;

    logic [COUNT_W-1:0] r_max_code_points;
    logic               r_stop_at_nul;

    t_in_item  in_item;
    t_in_item  stage_item;
    logic      stage_valid;
    t_step_ctl step_ctl;
    t_result   step_result;
    t_result   out_result;
    logic      out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_code_points <= MAX_CODE_POINTS_RST;
            r_stop_at_nul     <= STOP_AT_NUL_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MAX_CODE_POINTS: r_max_code_points <= i_cfg_wr_data;
                CFG_STOP_AT_NUL:     r_stop_at_nul     <= i_cfg_wr_data[0];
            endcase
        end
    end

    assign in_item.byte_in   = i_byte_in;
    assign in_item.last_byte = i_last_byte;

    utd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_advance (step_ctl.advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    utd_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (stage_valid),
        .i_item            (stage_item),
        .i_out_free        (out_free),
        .i_max_code_points (r_max_code_points),
        .i_stop_at_nul     (r_stop_at_nul),
        .o_ctl             (step_ctl),
        .o_result          (step_result)
    );

    utd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step_ctl.load),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_cp_value       = out_result.cp_value;
    assign o_has_code_point = out_result.has_code_point;
    assign o_end_of_string  = out_result.end_of_string;
    assign o_truncated      = out_result.truncated;
    assign o_units_written  = out_result.units_written;

endmodule
